@@ rtl/pmst_pkg.sv @@
// Shared constants, types and helpers for the Prim spanning tree block.
package pmst_pkg;

    localparam int W_WEIGHT         = 25;
    localparam int W_VTX            = 6;
    localparam int W_IN_IDX         = 5;
    localparam int W_CFG            = 6;
    localparam int MAX_VERTICES_DEF = 32;

    localparam logic [W_WEIGHT-1:0] NO_EDGE   = 25'd20200820;
    localparam logic [W_WEIGHT-1:0] KEY_START = 25'd20200821;

    localparam logic [W_CFG-1:0] VERTEX_COUNT_RST = 6'd32;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_RUN  = 1'b1;

    typedef struct packed {
        logic valid;
        logic init;
        logic first;
        logic last;
    } t_scan_cmd;

    function automatic logic [W_WEIGHT-1:0] edge_cost(input logic [W_WEIGHT-1:0] w);
        logic [W_WEIGHT-1:0] c;
        if ((w == '0) || (w >= NO_EDGE)) begin
            c = NO_EDGE;
        end else begin
            c = w;
        end
        return c;
    endfunction

endpackage

@@ rtl/pmst_key_unit.sv @@
// Key and source memory with read-modify-write relaxation and running minimum search.
module pmst_key_unit #(
    parameter int MAX_VERTICES = pmst_pkg::MAX_VERTICES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  pmst_pkg::t_scan_cmd                 i_cmd,
    input  logic [$clog2(MAX_VERTICES)-1:0]     i_idx,
    input  logic [$clog2(MAX_VERTICES)-1:0]     i_pick,
    input  logic [pmst_pkg::W_WEIGHT-1:0]       i_weight,
    output logic                                o_done,
    output logic [$clog2(MAX_VERTICES)-1:0]     o_best_idx,
    output logic [$clog2(MAX_VERTICES)-1:0]     o_best_src
);
    import pmst_pkg::*;

    localparam int IW = $clog2(MAX_VERTICES);

    typedef struct packed {
        logic [W_WEIGHT-1:0] key;
        logic [IW-1:0]       src;
    } t_entry;

    t_entry              r_mem [MAX_VERTICES];
    t_entry              r_rd;
    t_scan_cmd           r_cmd;
    logic [IW-1:0]       r_idx;
    logic                r_done;
    logic [W_WEIGHT-1:0] r_min_key;
    logic [IW-1:0]       r_min_idx;
    logic [IW-1:0]       r_min_src;

    t_entry              w_new;
    logic [W_WEIGHT-1:0] w_cost;
    logic [W_WEIGHT-1:0] w_base;
    logic                w_take;

    assign w_cost = edge_cost(i_weight);

    always_comb begin
        w_new = r_rd;
        if (r_cmd.init) begin
            w_new.key = (r_idx == '0) ? '0 : w_cost;
            w_new.src = '0;
        end else if (r_idx == i_pick) begin
            w_new.key = '0;
        end else if ((r_rd.key != '0) && (w_cost < r_rd.key)) begin
            w_new.key = w_cost;
            w_new.src = i_pick;
        end
    end

    assign w_base = r_cmd.first ? KEY_START : r_min_key;
    assign w_take = (w_new.key != '0) && (w_new.key < w_base);

    always_ff @(posedge i_clk) begin
        if (i_cmd.valid) begin
            r_rd <= r_mem[i_idx];
        end
        if (r_cmd.valid) begin
            r_mem[r_idx] <= w_new;
        end
        r_idx <= i_idx;
    end

    always_ff @(posedge i_clk) begin
        if (r_cmd.valid) begin
            if (w_take) begin
                r_min_key <= w_new.key;
                r_min_idx <= r_idx;
                r_min_src <= w_new.src;
            end else if (r_cmd.first) begin
                r_min_key <= KEY_START;
                r_min_idx <= '0;
                r_min_src <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cmd  <= i_cmd;
            r_done <= r_cmd.valid && r_cmd.last;
        end
    end

    assign o_done     = r_done;
    assign o_best_idx = r_min_idx;
    assign o_best_src = r_min_src;

endmodule

@@ rtl/prim_min_spanning_tree.sv @@
// Top level of the Prim minimum spanning tree block over an adjacency matrix.
//
// Input channel (i_in_valid / o_in_stall): a load item (i_op = 0) writes one
// matrix weight, and loads are taken back to back. A run item (i_op = 1)
// grows a tree from vertex 1 over the first vertex_count vertices and holds
// o_in_stall high until its last edge sits in the output register.
// Output channel (o_out_valid / i_out_stall): one item per tree edge, n-1 in
// all, the last one flagged. A stalled output holds its item and the run
// waits at the next edge.
// Scan: each tree edge takes a pass over the n vertices, read through the
// single read port of the adjacency memory and of the key memory, one vertex
// per cycle.
// Reset: all MAX_VERTICES*MAX_VERTICES matrix entries (1024 by default) are
// swept to zero, which reads as no edge, one entry per cycle, with o_in_stall
// high; configuration writes are taken throughout. vertex_count resets to 32.
module prim_min_spanning_tree #(
    parameter int MAX_VERTICES = pmst_pkg::MAX_VERTICES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [pmst_pkg::W_CFG-1:0]      i_cfg_wr_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_op,
    input  logic [pmst_pkg::W_IN_IDX-1:0]   i_row_vertex,
    input  logic [pmst_pkg::W_IN_IDX-1:0]   i_col_vertex,
    input  logic [pmst_pkg::W_WEIGHT-1:0]   i_edge_weight,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [pmst_pkg::W_VTX-1:0]      o_from_vertex,
    output logic [pmst_pkg::W_VTX-1:0]      o_to_vertex,
    output logic                            o_last_edge
);
    import pmst_pkg::*;

    localparam int IW        = $clog2(MAX_VERTICES);
    localparam int CW        = $clog2(MAX_VERTICES + 1);
    localparam int ADJ_DEPTH = MAX_VERTICES * MAX_VERTICES;
    localparam int AW        = $clog2(ADJ_DEPTH);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_WAIT  = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    logic [2:0]          r_state,    n_state;
    logic [AW-1:0]       r_clr_addr, n_clr_addr;
    logic [IW-1:0]       r_v,        n_v;
    logic [IW-1:0]       r_step,     n_step;
    logic [IW-1:0]       r_last_v,   n_last_v;
    logic                r_init,     n_init;
    logic [IW-1:0]       r_pick,     n_pick;
    logic [IW-1:0]       r_pick_src, n_pick_src;
    logic [W_CFG-1:0]    r_cfg;
    logic                r_out_valid;
    logic [W_VTX-1:0]    r_from;
    logic [W_VTX-1:0]    r_to;
    logic                r_last;

    logic [W_WEIGHT-1:0] r_adj [ADJ_DEPTH];
    logic [W_WEIGHT-1:0] r_adj_rd;

    logic                w_in_acc;
    logic                w_out_free;
    logic [CW-1:0]       w_n_eff;
    logic                w_run_ok;
    logic                w_load_ok;
    logic                w_adj_we;
    logic [AW-1:0]       w_adj_wa;
    logic [W_WEIGHT-1:0] w_adj_wd;
    logic [AW-1:0]       w_adj_ra;
    logic [IW-1:0]       w_row;
    t_scan_cmd           w_cmd;
    logic                w_done;
    logic [IW-1:0]       w_best_idx;
    logic [IW-1:0]       w_best_src;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    assign w_n_eff  = (32'(r_cfg) > 32'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : CW'(r_cfg);
    assign w_run_ok = (32'(w_n_eff) >= 32'd2);

    assign w_load_ok = (32'(i_row_vertex) < 32'(MAX_VERTICES))
                    && (32'(i_col_vertex) < 32'(MAX_VERTICES));

    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_v        = r_v;
        n_step     = r_step;
        n_last_v   = r_last_v;
        n_init     = r_init;
        n_pick     = r_pick;
        n_pick_src = r_pick_src;
        unique case (r_state)
            S_CLEAR: begin
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == AW'(ADJ_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_in_acc && (i_op == OP_RUN) && w_run_ok) begin
                    n_state  = S_SCAN;
                    n_init   = 1'b1;
                    n_v      = '0;
                    n_step   = IW'(1);
                    n_last_v = IW'(w_n_eff - 1'b1);
                end
            end
            S_SCAN: begin
                n_v = r_v + 1'b1;
                if (r_v == r_last_v) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (w_done) begin
                    n_state    = S_EMIT;
                    n_pick     = w_best_idx;
                    n_pick_src = w_best_src;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_step = r_step + 1'b1;
                    if (r_step == r_last_v) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_SCAN;
                        n_init  = 1'b0;
                        n_v     = '0;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_cfg      <= VERTEX_COUNT_RST;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            if (i_cfg_wr_en) begin
                r_cfg <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_v        <= n_v;
        r_step     <= n_step;
        r_last_v   <= n_last_v;
        r_init     <= n_init;
        r_pick     <= n_pick;
        r_pick_src <= n_pick_src;
    end

    always_comb begin
        w_adj_we = 1'b0;
        w_adj_wa = r_clr_addr;
        w_adj_wd = '0;
        if (r_state == S_CLEAR) begin
            w_adj_we = 1'b1;
        end else if (w_in_acc && (i_op == OP_LOAD) && w_load_ok) begin
            w_adj_we = 1'b1;
            w_adj_wa = AW'(i_row_vertex) * AW'(MAX_VERTICES) + AW'(i_col_vertex);
            w_adj_wd = i_edge_weight;
        end
    end

    assign w_row    = r_init ? '0 : r_pick;
    assign w_adj_ra = AW'(w_row) * AW'(MAX_VERTICES) + AW'(r_v);

    always_ff @(posedge i_clk) begin
        if (w_adj_we) begin
            r_adj[w_adj_wa] <= w_adj_wd;
        end
        if (r_state == S_SCAN) begin
            r_adj_rd <= r_adj[w_adj_ra];
        end
    end

    assign w_cmd.valid = (r_state == S_SCAN);
    assign w_cmd.init  = r_init;
    assign w_cmd.first = (r_v == '0);
    assign w_cmd.last  = (r_v == r_last_v);

    pmst_key_unit #(
        .MAX_VERTICES(MAX_VERTICES)
    ) u_key_unit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_idx      (r_v),
        .i_pick     (r_pick),
        .i_weight   (r_adj_rd),
        .o_done     (w_done),
        .o_best_idx (w_best_idx),
        .o_best_src (w_best_src)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_EMIT) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_EMIT) && w_out_free) begin
            r_from <= W_VTX'((IW + 1)'(r_pick_src) + 1'b1);
            r_to   <= W_VTX'((IW + 1)'(r_pick) + 1'b1);
            r_last <= (r_step == r_last_v);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_from_vertex = r_from;
    assign o_to_vertex   = r_to;
    assign o_last_edge   = r_last;

`ifndef SYNTHESIS
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> (r_state == S_WAIT))
        else $error("scan completion outside wait state");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_v <= r_last_v))
        else $error("scan index beyond vertex count");

    a_out_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_EMIT))
        else $error("output item raised outside emit state");

    a_pick_not_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_pick != '0))
        else $error("root vertex picked as new tree vertex");
`endif

endmodule
